// ===== src/tga_rle_pixel_decoder_macros.svh =====
// assertion macros for the tga run-length pixel decoder
// no dependencies; included by modules that carry assertions
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// condition holds on every clock edge out of reset
`define TRLD_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TRLD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/trld_pkg.sv =====
// shared types and constants of the tga run-length pixel decoder
// no dependencies
`default_nettype none

package trld_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] CFG_IMAGE_WIDTH      = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT     = 2'd1;
  localparam logic [1:0] CFG_FOUR_BYTE_PIXELS = 2'd2;

  localparam logic [7:0] RUN_FLAG_MIN = 8'd128;
  localparam logic [7:0] RUN_BIAS     = 8'd127;

  // decoded event passed from front to back
  typedef struct packed {
    logic       is_frame;
    logic       is_run;
    logic [7:0] count;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        four_byte_pixels;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/tga_rle_pixel_decoder.sv =====
// top level of the tga run-length pixel decoder: config registers, front, queue, back
// depends on trld_pkg, trld_front, trld_fifo and trld_back
//
//   port group  direction  handshake          payload
//   in_*        input      in_valid/in_ready   stream_byte, frame_start
//   out_*       output     out_valid/out_ready start_pixel, colour, run_length, image_done
//   cfg_*       input      cfg_we              cfg_index, cfg_data
//
// one byte accepted per cycle while the four-entry event queue has room
// the byte that ends a pixel pushes its event into the queue, and the back end moves it to the output register
// a stalled output fills the queue, then in_ready drops
// reset is synchronous; no clearing pass, the block is ready in the first cycle after reset
`default_nettype none

module tga_rle_pixel_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_stream_byte,
  input  wire logic        in_frame_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_start_pixel,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic [7:0]       out_run_length,
  output logic             out_image_done,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  trld_pkg::cfg_t   cfg_r, cfg_nxt;
  trld_pkg::pixel_t q_wdata, q_rdata;
  logic             q_push, q_pop, q_empty, q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        trld_pkg::CFG_IMAGE_WIDTH:      cfg_nxt.image_width      = cfg_data;
        trld_pkg::CFG_IMAGE_HEIGHT:     cfg_nxt.image_height     = cfg_data;
        trld_pkg::CFG_FOUR_BYTE_PIXELS: cfg_nxt.four_byte_pixels = cfg_data[0];
        default:                        cfg_nxt                  = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width      <= 16'd1;
      cfg_r.image_height     <= 16'd1;
      cfg_r.four_byte_pixels <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  trld_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stream_byte   (in_stream_byte),
    .in_frame_start   (in_frame_start),
    .four_byte_pixels (cfg_r.four_byte_pixels),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  trld_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  trld_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_start_pixel (out_start_pixel),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_run_length  (out_run_length),
    .out_image_done  (out_image_done)
  );

endmodule

`default_nettype wire

// ===== src/trld_front.sv =====
// front end: accepts packet bytes, tracks packet headers, assembles pixels
// depends on trld_pkg
`default_nettype none

module trld_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_stream_byte,
  input  wire logic                in_frame_start,
  input  wire logic                four_byte_pixels,
  input  wire logic                q_full,
  output logic                     q_push,
  output trld_pkg::pixel_t         q_wdata
);

  logic        in_pixel_r, in_pixel_nxt;
  logic        is_run_r, is_run_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [23:0] held_r, held_nxt;
  logic        accept;
  logic [1:0]  last_pos;
  logic        hdr_run;
  logic [7:0]  hdr_count;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign last_pos  = four_byte_pixels ? 2'd3 : 2'd2;
  assign hdr_run   = (in_stream_byte >= trld_pkg::RUN_FLAG_MIN);
  assign hdr_count = hdr_run ? (in_stream_byte - trld_pkg::RUN_BIAS) : (in_stream_byte + 8'd1);

  always_comb begin
    in_pixel_nxt = in_pixel_r;
    is_run_nxt   = is_run_r;
    left_nxt     = left_r;
    bip_nxt      = bip_r;
    held_nxt     = held_r;
    q_push       = 1'b0;
    q_wdata      = '0;
    if (accept) begin
      if (in_frame_start || !in_pixel_r) begin
        // packet header, new frame clears the packet first
        q_push           = in_frame_start;
        q_wdata.is_frame = 1'b1;
        in_pixel_nxt     = 1'b1;
        is_run_nxt       = hdr_run;
        left_nxt         = hdr_count;
        bip_nxt          = 2'd0;
        if (in_frame_start) begin
          held_nxt = '0;
        end
      end else if (bip_r < last_pos) begin
        unique case (bip_r)
          2'd0:    held_nxt[7:0]   = in_stream_byte;
          2'd1:    held_nxt[15:8]  = in_stream_byte;
          2'd2:    held_nxt[23:16] = in_stream_byte;
          default: held_nxt        = held_r;
        endcase
        bip_nxt = bip_r + 2'd1;
      end else begin
        q_push         = 1'b1;
        q_wdata.is_run = is_run_r;
        q_wdata.count  = left_r;
        q_wdata.blue   = held_r[7:0];
        q_wdata.green  = held_r[15:8];
        q_wdata.red    = four_byte_pixels ? held_r[23:16] : in_stream_byte;
        q_wdata.alpha  = four_byte_pixels ? in_stream_byte : 8'd0;
        bip_nxt        = 2'd0;
        held_nxt       = '0;
        if (is_run_r) begin
          left_nxt     = 8'd0;
          in_pixel_nxt = 1'b0;
        end else begin
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            in_pixel_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pixel_r <= 1'b0;
      is_run_r   <= 1'b0;
      left_r     <= 8'd0;
      bip_r      <= 2'd0;
      held_r     <= '0;
    end else begin
      in_pixel_r <= in_pixel_nxt;
      is_run_r   <= is_run_nxt;
      left_r     <= left_nxt;
      bip_r      <= bip_nxt;
      held_r     <= held_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/trld_fifo.sv =====
// short queue of decoded events between front and back
// depends on trld_pkg and the assertion macro header
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"

module trld_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire trld_pkg::pixel_t wdata,
  input  wire logic             pop,
  output trld_pkg::pixel_t      rdata,
  output logic                  empty,
  output logic                  full
);

  trld_pkg::pixel_t                 mem_r [trld_pkg::QDEPTH];
  logic [trld_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [trld_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [trld_pkg::QCNT_W-1:0]      count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == trld_pkg::QCNT_W'(trld_pkg::QDEPTH));
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + trld_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + trld_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + trld_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - trld_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `TRLD_ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, !full, "push into full queue")
  `TRLD_ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

// ===== src/trld_back.sv =====
// back end: pixel cursor, run clipping, frame completion and output register
// depends on trld_pkg and the assertion macro header
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"

module trld_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire trld_pkg::cfg_t   cfg,
  input  wire logic             q_empty,
  input  wire trld_pkg::pixel_t q_rdata,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           out_start_pixel,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  output logic [7:0]            out_run_length,
  output logic                  out_image_done
);

  logic        complete_r, complete_nxt;
  logic [31:0] cursor_r, cursor_nxt;
  logic [31:0] total_r, total_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] start_r;
  logic [7:0]  red_r, green_r, blue_r, alpha_r, len_r;
  logic        done_r;
  logic [31:0] remaining;
  logic [7:0]  req_len;
  logic [7:0]  len;
  logic [31:0] cursor_add;
  logic        emit;

  assign q_pop      = !q_empty && (!out_valid_r || out_ready);
  assign remaining  = total_r - cursor_r;
  assign req_len    = q_rdata.is_run ? q_rdata.count : 8'd1;
  assign len        = ({24'd0, req_len} > remaining) ? remaining[7:0] : req_len;
  assign cursor_add = cursor_r + {24'd0, len};
  assign emit       = q_pop && !q_rdata.is_frame && !complete_r;

  always_comb begin
    complete_nxt  = complete_r;
    cursor_nxt    = cursor_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (q_pop) begin
      if (q_rdata.is_frame) begin
        cursor_nxt   = 32'd0;
        total_nxt    = {16'd0, cfg.image_width} * {16'd0, cfg.image_height};
        complete_nxt = (cfg.image_width == 16'd0) || (cfg.image_height == 16'd0);
      end else if (!complete_r) begin
        out_valid_nxt = 1'b1;
        cursor_nxt    = cursor_add;
        complete_nxt  = (cursor_add >= total_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      complete_r  <= 1'b1;
      cursor_r    <= 32'd0;
      total_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      complete_r  <= complete_nxt;
      cursor_r    <= cursor_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      start_r <= cursor_r;
      red_r   <= q_rdata.red;
      green_r <= q_rdata.green;
      blue_r  <= q_rdata.blue;
      alpha_r <= q_rdata.alpha;
      len_r   <= len;
      done_r  <= (cursor_add >= total_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_start_pixel = start_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;
  assign out_alpha       = alpha_r;
  assign out_run_length  = len_r;
  assign out_image_done  = done_r;

  `TRLD_ASSERT_ALWAYS(a_cursor_in_frame, clk, rst_n, complete_r || (cursor_r < total_r), "cursor past pixel total in open frame")
  `TRLD_ASSERT_IMPLY(a_len_nonzero, clk, rst_n, out_valid_r, len_r != 8'd0, "zero run length presented")

endmodule

`default_nettype wire

// ===== dv/tga_rle_pixel_decoder_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for tga_rle_pixel_decoder: directed and random packet streams
// depends on trld_pkg and the decoder rtl; predicts every pixel result and checks it per field

module tga_rle_pixel_decoder_tb;

  localparam int unsigned ITEM_TARGET  = 600;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       frame_start;
  } stream_req_t;

  typedef struct packed {
    logic [31:0] start_pixel;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic        image_done;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_stream_byte = 8'd0;
  logic        in_frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_start_pixel;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [7:0]  out_run_length;
  logic        out_image_done;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  tga_rle_pixel_decoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_stream_byte  (in_stream_byte),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_start_pixel (out_start_pixel),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_run_length  (out_run_length),
    .out_image_done  (out_image_done),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  // shadow registers
  logic [15:0] cfg_width_m  = 16'd1;
  logic [15:0] cfg_height_m = 16'd1;
  logic        cfg_four_m   = 1'b0;

  // decoder state
  logic        pk_in_pixel = 1'b0;
  logic        pk_is_run   = 1'b0;
  logic [7:0]  pk_left     = 8'd0;
  logic [1:0]  pk_pos      = 2'd0;
  logic [23:0] pk_held     = 24'd0;
  logic [31:0] px_cursor   = 32'd0;
  logic [31:0] px_total    = 32'd0;
  logic        frame_done  = 1'b1;

  stream_req_t   byte_q[$];
  pixel_result_t pixel_results_q[$];
  stream_req_t   next_req;
  pixel_result_t oldest_result;

  int unsigned requests_pending = 0;
  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  bit          no_idle = 1'b0;
  bit          long_hold_req = 1'b0;

  function automatic void clear_packet_state();
    pk_in_pixel = 1'b0;
    pk_is_run   = 1'b0;
    pk_left     = 8'd0;
    pk_pos      = 2'd0;
    pk_held     = 24'd0;
  endfunction

  function automatic void decode_stream_byte(input logic [7:0] sb, input logic fs);
    logic [1:0]    last_pos;
    logic [31:0]   remaining;
    logic [31:0]   span;
    pixel_result_t res;
    if (fs) begin
      clear_packet_state();
      px_cursor  = 32'd0;
      px_total   = 32'(cfg_width_m) * 32'(cfg_height_m);
      frame_done = (px_total == 32'd0);
    end
    if (frame_done) return;

    if (!pk_in_pixel) begin
      if (sb < trld_pkg::RUN_FLAG_MIN) begin
        pk_is_run = 1'b0;
        pk_left   = sb + 8'd1;
      end else begin
        pk_is_run = 1'b1;
        pk_left   = sb - trld_pkg::RUN_BIAS;
      end
      pk_in_pixel = 1'b1;
      pk_pos      = 2'd0;
      return;
    end

    // pixel width is taken live, so a switch mid-pixel ends it early or late
    last_pos = cfg_four_m ? 2'd3 : 2'd2;
    if (pk_pos < last_pos) begin
      pk_held[8*pk_pos +: 8] = sb;
      pk_pos = pk_pos + 2'd1;
      return;
    end

    res.blue  = pk_held[7:0];
    res.green = pk_held[15:8];
    if (cfg_four_m) begin
      res.red   = pk_held[23:16];
      res.alpha = sb;
    end else begin
      res.red   = sb;
      res.alpha = 8'd0;
    end
    remaining = px_total - px_cursor;
    span = pk_is_run ? 32'(pk_left) : 32'd1;
    if (span > remaining) span = remaining;
    res.start_pixel = px_cursor;
    res.run_length  = span[7:0];
    px_cursor       = px_cursor + span;
    res.image_done  = (px_cursor >= px_total);
    pixel_results_q.push_back(res);

    pk_pos  = 2'd0;
    pk_held = 24'd0;
    if (pk_is_run) begin
      pk_left     = 8'd0;
      pk_in_pixel = 1'b0;
    end else begin
      pk_left = pk_left - 8'd1;
      if (pk_left == 8'd0) pk_in_pixel = 1'b0;
    end
    if (res.image_done) begin
      frame_done = 1'b1;
      clear_packet_state();
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  // request and result acceptance
  always @(posedge clk) begin
    in_taken  = rst_n && in_valid && in_ready;
    out_taken = rst_n && out_valid && out_ready;
    if (in_taken) begin
      decode_stream_byte(in_stream_byte, in_frame_start);
      requests_pending--;
    end
    if (out_taken) begin
      if (pixel_results_q.size() == 0) begin
        $display("%0t: result expected none got start_pixel %0h run_length %0h",
                 $time, out_start_pixel, out_run_length);
        mismatch_count++;
      end else begin
        oldest_result = pixel_results_q.pop_front();
        check_field("start_pixel", oldest_result.start_pixel, out_start_pixel);
        check_field("red", 32'(oldest_result.red), 32'(out_red));
        check_field("green", 32'(oldest_result.green), 32'(out_green));
        check_field("blue", 32'(oldest_result.blue), 32'(out_blue));
        check_field("alpha", 32'(oldest_result.alpha), 32'(out_alpha));
        check_field("run_length", 32'(oldest_result.run_length), 32'(out_run_length));
        check_field("image_done", 32'(oldest_result.image_done), 32'(out_image_done));
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (byte_q.size() != 0) begin
        next_req = byte_q.pop_front();
        in_valid       <= 1'b1;
        in_stream_byte <= next_req.stream_byte;
        in_frame_start <= next_req.frame_start;
        send_gap = draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) recv_gap = draw_gap();
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        recv_gap = LONG_HOLD;
      end
      if (recv_gap != 0) begin
        out_ready <= 1'b0;
        recv_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic fs);
    stream_req_t r;
    r.stream_byte = b;
    r.frame_start = fs;
    byte_q.push_back(r);
    requests_pending++;
    items_sent++;
  endtask

  task automatic push_pixel();
    repeat (cfg_four_m ? 4 : 3) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic push_packet(input logic fs);
    logic [7:0]  hdr;
    int unsigned n;
    if ($urandom_range(0, 1)) hdr = 8'($urandom_range(128, 255));
    else if ($urandom_range(0, 19) == 0) hdr = 8'($urandom_range(0, 127));
    else hdr = 8'($urandom_range(0, 7));
    push_byte(hdr, fs);
    n = (hdr >= trld_pkg::RUN_FLAG_MIN) ? 1 : hdr + 1;
    repeat (n) push_pixel();
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  // called on a falling edge, returns on a falling edge
  task automatic settle();
    do @(negedge clk); while (requests_pending != 0 || pixel_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      trld_pkg::CFG_IMAGE_WIDTH:      cfg_width_m = data;
      trld_pkg::CFG_IMAGE_HEIGHT:     cfg_height_m = data;
      trld_pkg::CFG_FOUR_BYTE_PIXELS: cfg_four_m = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r < 3) return 16'hFFFF;
    if (r == 3) return 16'($urandom_range(1, 65535));
    return 16'($urandom_range(1, 10));
  endfunction

  initial begin
    int unsigned n_packets;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 3x2 image: byte before any frame, raw pair at colour extremes, clipped run, trailing byte
    write_reg(trld_pkg::CFG_IMAGE_WIDTH, 16'd3);
    write_reg(trld_pkg::CFG_IMAGE_HEIGHT, 16'd2);
    @(posedge clk);
    push_byte(8'h55, 1'b0);
    push_byte(8'h01, 1'b1);
    repeat (3) push_byte(8'h00, 1'b0);
    repeat (3) push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'hAA, 1'b0);
    settle();

    // empty image
    write_reg(trld_pkg::CFG_IMAGE_WIDTH, 16'd0);
    write_reg(trld_pkg::CFG_FOUR_BYTE_PIXELS, 16'd1);
    @(posedge clk);
    push_byte(8'h80, 1'b1);
    push_byte(8'h00, 1'b0);
    settle();

    // largest image, pixel width switched part way through a pixel both ways
    write_reg(trld_pkg::CFG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(trld_pkg::CFG_IMAGE_HEIGHT, 16'hFFFF);
    @(posedge clk);
    push_byte(8'h7F, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h04, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    settle();
    write_reg(trld_pkg::CFG_FOUR_BYTE_PIXELS, 16'd0);
    @(posedge clk);
    push_byte(8'h9C, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    settle();
    write_reg(trld_pkg::CFG_FOUR_BYTE_PIXELS, 16'd1);
    @(posedge clk);
    push_byte(8'h33, 1'b0);
    push_byte(8'h44, 1'b0);
    settle();

    // long output stall with a raw packet behind it
    write_reg(trld_pkg::CFG_FOUR_BYTE_PIXELS, 16'd0);
    @(posedge clk);
    long_hold_req = 1'b1;
    push_byte(8'h3F, 1'b1);
    repeat (64) push_pixel();
    settle();

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 1)) write_reg(trld_pkg::CFG_IMAGE_WIDTH, pick_dim());
      if ($urandom_range(0, 1)) write_reg(trld_pkg::CFG_IMAGE_HEIGHT, pick_dim());
      if ($urandom_range(0, 2) == 0) write_reg(trld_pkg::CFG_FOUR_BYTE_PIXELS, 16'($urandom));
      @(posedge clk);
      no_idle = ($urandom_range(0, 3) == 0);
      n_packets = $urandom_range(1, 8);
      for (int k = 0; k < n_packets; k++) begin
        if ($urandom_range(0, 6) == 0) push_noise();
        else if (k == 0) push_packet($urandom_range(0, 3) != 0);
        else push_packet($urandom_range(0, 19) == 0);
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
